// ===== src/tdri_pkg.sv =====
// Shared types and constants of the text data row indexer.
package tdri_pkg;

  localparam int unsigned ROW_BITS   = 32;
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned CFG_BITS   = 64;
  localparam int unsigned CNT_BITS   = 4;
  localparam int unsigned HDR_BITS   = 16;
  localparam int unsigned IDX_BITS   = 2;

  localparam logic [IDX_BITS-1:0] CFG_COMMENT_CHARS = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_COMMENT_COUNT = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_HEADER_LINES  = 2'd2;

  localparam logic [CFG_BITS-1:0] COMMENT_CHARS_RST = 64'h0000_003B_2163_2F23;
  localparam logic [CNT_BITS-1:0] COMMENT_COUNT_RST = 4'd5;
  localparam logic [HDR_BITS-1:0] HEADER_LINES_RST  = 16'd0;

  localparam logic [7:0] BYTE_HT = 8'h09;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_SP = 8'h20;

  typedef struct packed {
    logic comment_hit;
    logic is_lf;
    logic is_cr;
    logic is_white;
  } byte_class_t;

endpackage

// ===== src/text_data_row_indexer.sv =====
// Top level of the text data row indexer: ports, configuration and input stage.
//   Channel | Direction | Handshake          | Payload
//   in_     | request   | in_valid/in_ready  | in_text_byte
//   out_    | result    | out_valid/out_ready| row_number, row_begin, row_finish, overflow
//   cfg_    | write     | cfg_wr_en          | cfg_index, cfg_wr_data
// A byte is taken every cycle unless a result stalls. The byte register feeds the
// combinational classifier and counter update, which load the result register with
// a line end's result. A stalled result holds the byte register; input waits only then.
// Reset is synchronous and restores the configuration defaults and all counters.
module text_data_row_indexer #(
  parameter int unsigned OFFSET_BITS       = 32,
  parameter int unsigned MAX_COMMENT_CHARS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_text_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tdri_pkg::FIELD_BITS-1:0] out_row_number,
  output logic [tdri_pkg::FIELD_BITS-1:0] out_row_begin,
  output logic [tdri_pkg::FIELD_BITS-1:0] out_row_finish,
  output logic                            out_overflow,
  input  logic                            cfg_wr_en,
  input  logic [tdri_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [tdri_pkg::CFG_BITS-1:0]   cfg_wr_data
);
  import tdri_pkg::*;

  logic [CFG_BITS-1:0] comment_chars_r;
  logic [CNT_BITS-1:0] comment_count_r;
  logic                hdr_load;
  logic [7:0]          byte_r;
  logic                byte_valid_r;
  logic                step;
  byte_class_t         cls;

  assign hdr_load = cfg_wr_en && (cfg_index == CFG_HEADER_LINES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comment_chars_r <= COMMENT_CHARS_RST;
      comment_count_r <= COMMENT_COUNT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_COMMENT_CHARS) begin
        comment_chars_r <= cfg_wr_data;
      end
      if (cfg_index == CFG_COMMENT_COUNT) begin
        comment_count_r <= cfg_wr_data[CNT_BITS-1:0];
      end
    end
  end

  assign step     = byte_valid_r && (!out_valid || out_ready);
  assign in_ready = !byte_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid_r <= 1'b1;
    end else if (step) begin
      byte_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_text_byte;
    end
  end

  tdri_classify #(
    .MAX_COMMENT_CHARS(MAX_COMMENT_CHARS)
  ) u_classify (
    .text_byte    (byte_r),
    .comment_chars(comment_chars_r),
    .comment_count(comment_count_r),
    .cls          (cls)
  );

  tdri_tracker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cls       (cls),
    .hdr_load  (hdr_load),
    .hdr_value (cfg_wr_data[HDR_BITS-1:0]),
    .out_take  (out_valid && out_ready),
    .out_valid (out_valid),
    .row_number(out_row_number),
    .row_begin (out_row_begin),
    .row_finish(out_row_finish),
    .overflow  (out_overflow)
  );

endmodule

// ===== src/tdri_classify.sv =====
// Byte classifier: comment set match, line ends and whitespace.
module tdri_classify #(
  parameter int unsigned MAX_COMMENT_CHARS = 8
) (
  input  logic [7:0]                      text_byte,
  input  logic [tdri_pkg::CFG_BITS-1:0]   comment_chars,
  input  logic [tdri_pkg::CNT_BITS-1:0]   comment_count,
  output tdri_pkg::byte_class_t           cls
);
  import tdri_pkg::*;

  localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_COMMENT_CHARS);

  logic [CNT_BITS-1:0] count_eff;
  logic                hit;

  always_comb begin
    count_eff = (comment_count > MAX_CNT) ? MAX_CNT : comment_count;
    hit = 1'b0;
    for (int k = 0; k < MAX_COMMENT_CHARS; k++) begin
      if ((CNT_BITS'(k) < count_eff) && (comment_chars[8*k +: 8] == text_byte)) begin
        hit = 1'b1;
      end
    end
  end

  assign cls.comment_hit = hit;
  assign cls.is_lf       = (text_byte == BYTE_LF);
  assign cls.is_cr       = (text_byte == BYTE_CR);
  assign cls.is_white    = (text_byte == BYTE_SP) ||
                           ((text_byte >= BYTE_HT) && (text_byte <= BYTE_CR));

endmodule

// ===== src/tdri_tracker.sv =====
// Line state, offset and row counters, and the result register.
module tdri_tracker #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  tdri_pkg::byte_class_t           cls,
  input  logic                            hdr_load,
  input  logic [tdri_pkg::HDR_BITS-1:0]   hdr_value,
  input  logic                            out_take,
  output logic                            out_valid,
  output logic [tdri_pkg::FIELD_BITS-1:0] row_number,
  output logic [tdri_pkg::FIELD_BITS-1:0] row_begin,
  output logic [tdri_pkg::FIELD_BITS-1:0] row_finish,
  output logic                            overflow
);
  import tdri_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [ROW_BITS-1:0]    ROWS_MAX   = '1;

  logic [OFFSET_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic [OFFSET_BITS-1:0] row_start_r, row_start_nxt;
  logic [ROW_BITS-1:0]    rows_done_r, rows_done_nxt;
  logic [HDR_BITS-1:0]    header_left_r, header_left_nxt;
  logic                   in_comment_r, in_comment_nxt;
  logic                   has_data_r, has_data_nxt;
  logic                   sat_r, sat_nxt;
  logic                   emit;
  logic [OFFSET_BITS-1:0] after;
  logic [HDR_BITS-1:0]    header_dec;

  logic                   out_valid_r, out_valid_nxt;
  logic [FIELD_BITS-1:0]  row_number_r, row_begin_r, row_finish_r;
  logic                   overflow_r;

  always_comb begin
    byte_offset_nxt = byte_offset_r;
    row_start_nxt   = row_start_r;
    rows_done_nxt   = rows_done_r;
    header_left_nxt = header_left_r;
    in_comment_nxt  = in_comment_r;
    has_data_nxt    = has_data_r;
    sat_nxt         = sat_r;
    emit            = 1'b0;
    after           = (byte_offset_r == OFFSET_MAX) ? OFFSET_MAX : byte_offset_r + 1'b1;
    header_dec      = header_left_r - 1'b1;
    if (step) begin
      byte_offset_nxt = after;
      if (byte_offset_r == OFFSET_MAX) begin
        sat_nxt = 1'b1;
      end
      if (header_left_r != '0) begin
        if (cls.is_lf) begin
          header_left_nxt = header_dec;
          if (header_dec == '0) begin
            row_start_nxt = after;
          end
        end
      end else if (cls.comment_hit) begin
        in_comment_nxt = 1'b1;
      end else if (cls.is_lf || cls.is_cr) begin
        if (has_data_r) begin
          emit = 1'b1;
          if (rows_done_r == ROWS_MAX) begin
            sat_nxt = 1'b1;
          end else begin
            rows_done_nxt = rows_done_r + 1'b1;
          end
        end
        row_start_nxt  = after;
        in_comment_nxt = 1'b0;
        has_data_nxt   = 1'b0;
      end else if (!in_comment_r && !cls.is_white) begin
        has_data_nxt = 1'b1;
      end
    end
    if (hdr_load) begin
      header_left_nxt = hdr_value;
    end
    out_valid_nxt = emit || (out_valid_r && !out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      row_start_r   <= '0;
      rows_done_r   <= '0;
      header_left_r <= HEADER_LINES_RST;
      in_comment_r  <= 1'b0;
      has_data_r    <= 1'b0;
      sat_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      byte_offset_r <= byte_offset_nxt;
      row_start_r   <= row_start_nxt;
      rows_done_r   <= rows_done_nxt;
      header_left_r <= header_left_nxt;
      in_comment_r  <= in_comment_nxt;
      has_data_r    <= has_data_nxt;
      sat_r         <= sat_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row_number_r <= FIELD_BITS'(rows_done_r);
      row_begin_r  <= FIELD_BITS'(row_start_r);
      row_finish_r <= FIELD_BITS'(after);
      overflow_r   <= sat_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign row_number = row_number_r;
  assign row_begin  = row_begin_r;
  assign row_finish = row_finish_r;
  assign overflow   = overflow_r;

endmodule

// ===== src/tdri_checker.sv =====
// Port checker for the text data row indexer, bound to the top level.
module tdri_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tdri_pkg::FIELD_BITS-1:0] out_row_number,
  input logic [tdri_pkg::FIELD_BITS-1:0] out_row_begin,
  input logic [tdri_pkg::FIELD_BITS-1:0] out_row_finish,
  input logic                            out_overflow
);
  import tdri_pkg::*;

  logic                  have_prev_r;
  logic [FIELD_BITS-1:0] prev_row_r;
  logic                  prev_ovf_r;
  logic                  out_acc;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (out_acc) begin
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_row_r <= out_row_number;
      prev_ovf_r <= out_overflow;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_number) &&
    $stable(out_row_begin) && $stable(out_row_finish) && $stable(out_overflow))
    else $error("Stalled result changed.");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && have_prev_r && !out_overflow |-> out_row_number == prev_row_r + 1'b1)
    else $error("Row number did not advance by one.");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && have_prev_r && prev_ovf_r |-> out_overflow)
    else $error("Overflow flag dropped.");

endmodule

bind text_data_row_indexer tdri_checker u_tdri_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_row_number(out_row_number),
  .out_row_begin (out_row_begin),
  .out_row_finish(out_row_finish),
  .out_overflow  (out_overflow)
);
